[src/bole_pkg.sv]
// Shared constants and types for the bounded ordered list engine.
`default_nettype none

package bole_pkg;

   localparam int LIST_DEPTH_DEF   = 16;
   localparam int HANDLE_WIDTH_DEF = 32;

   localparam int OPCODE_W      = 3;
   localparam int POSITION_W    = 4;
   localparam int HANDLE_PORT_W = 32;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND    = 3'd0,
      OP_CLEAR     = 3'd1,
      OP_GET       = 3'd2,
      OP_SWAP_DOWN = 3'd3,
      OP_SWAP_UP   = 3'd4,
      OP_REMOVE    = 3'd5,
      OP_REPLACE   = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_ZERO   = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADIDX = 2'd3
   } status_type;

endpackage

`default_nettype wire

[src/bole_store.sv]
// Entry store: one write port and one registered read port.
`default_nettype none

module bole_store #(
   parameter int LIST_DEPTH   = 16,
   parameter int HANDLE_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(LIST_DEPTH)-1:0]   wr_addr,
   input  wire logic [HANDLE_WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(LIST_DEPTH)-1:0]   rd_addr,
   output      logic [HANDLE_WIDTH-1:0]         rd_data
);

   logic [HANDLE_WIDTH-1:0] mem_ff [LIST_DEPTH];
   logic [HANDLE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/bole_ctrl.sv]
// Sequencer: decodes a request, steps the store through its reads and writes, holds the response.
`default_nettype none

module bole_ctrl #(
   parameter int LIST_DEPTH   = 16,
   parameter int HANDLE_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic [bole_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire logic [bole_pkg::POSITION_W-1:0]       req_position,
   input  wire logic [bole_pkg::HANDLE_PORT_W-1:0]    req_handle_in,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic [bole_pkg::STATUS_W-1:0]         rsp_status,
   output      logic [bole_pkg::HANDLE_PORT_W-1:0]    rsp_handle_out,
   output      logic [bole_pkg::ENTRY_COUNT_W-1:0]    rsp_entry_count,
   output      logic                                  mem_wr_en,
   output      logic [$clog2(LIST_DEPTH)-1:0]         mem_wr_addr,
   output      logic [HANDLE_WIDTH-1:0]               mem_wr_data,
   output      logic [$clog2(LIST_DEPTH)-1:0]         mem_rd_addr,
   input  wire logic [HANDLE_WIDTH-1:0]               mem_rd_data
);

   import bole_pkg::*;

   localparam int ADDR_W = $clog2(LIST_DEPTH);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W  = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [HANDLE_WIDTH-1:0] handle_type;

   typedef enum logic [3:0] {
      IDLE,
      GET_WAIT,
      SWAP_RD2,
      SWAP_WR1,
      SWAP_WR2,
      REM_HEAD,
      REM_SHIFT,
      REP_WR,
      DONE
   } state_type;

   state_type  state_ff, state_in;
   cnt_type    count_ff, count_in;
   idx_type    cur_ff, cur_in;
   idx_type    wa_ff, wa_in;
   handle_type hold_ff, hold_in;
   handle_type hreq_ff, hreq_in;
   status_type status_ff, status_in;
   handle_type hout_ff, hout_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [HANDLE_PORT_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   opcode_type op;
   idx_type    pos_ext;
   idx_type    count_ext;
   handle_type h_req;
   logic       idx_ok;
   idx_type    step_idx;
   logic       step_ok;

   assign op        = opcode_type'(req_opcode);
   assign pos_ext   = idx_type'(req_position);
   assign count_ext = idx_type'(count_ff);
   assign h_req     = handle_type'(req_handle_in);
   assign idx_ok    = pos_ext < count_ext;

   // shared cursor step: next index and its bound check
   assign step_idx  = idx_type'(cur_ff + 1'b1);
   assign step_ok   = step_idx < count_ext;

   assign req_stall = (state_ff != IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      wa_in         = wa_ff;
      hold_in       = hold_ff;
      hreq_in       = hreq_ff;
      status_in     = status_ff;
      hout_in       = hout_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_type'(cur_ff);
      mem_wr_data   = mem_rd_data;
      mem_rd_addr   = addr_type'(pos_ext);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               status_in = ST_OK;
               hout_in   = '0;
               cur_in    = pos_ext;
               hreq_in   = h_req;
               state_in  = DONE;
               unique case (op)
                  OP_APPEND: begin
                     if (h_req == '0) begin
                        status_in = ST_ZERO;
                     end else if (count_ff == cnt_type'(LIST_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = addr_type'(count_ff);
                        mem_wr_data = h_req;
                        count_in    = cnt_type'(count_ff + 1'b1);
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_GET: begin
                     if (!idx_ok) begin
                        status_in = ST_BADIDX;
                     end else begin
                        state_in = GET_WAIT;
                     end
                  end
                  OP_SWAP_DOWN: begin
                     if (!idx_ok) begin
                        status_in = ST_BADIDX;
                     end else if (idx_type'(pos_ext + 1'b1) < count_ext) begin
                        state_in = SWAP_RD2;
                     end
                  end
                  OP_SWAP_UP: begin
                     if (!idx_ok) begin
                        status_in = ST_BADIDX;
                     end else if (pos_ext != '0) begin
                        cur_in      = idx_type'(pos_ext - 1'b1);
                        mem_rd_addr = addr_type'(cur_in);
                        state_in    = SWAP_RD2;
                     end
                  end
                  OP_REMOVE: begin
                     if (!idx_ok) begin
                        status_in = ST_BADIDX;
                     end else begin
                        state_in = REM_HEAD;
                     end
                  end
                  OP_REPLACE: begin
                     if (h_req == '0) begin
                        status_in = ST_ZERO;
                     end else if (!idx_ok) begin
                        status_in = ST_BADIDX;
                     end else begin
                        state_in = REP_WR;
                     end
                  end
                  default: begin
                     state_in = DONE;
                  end
               endcase
            end
         end
         GET_WAIT: begin
            hout_in  = mem_rd_data;
            state_in = DONE;
         end
         SWAP_RD2: begin
            hold_in     = mem_rd_data;
            mem_rd_addr = addr_type'(step_idx);
            state_in    = SWAP_WR1;
         end
         SWAP_WR1: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_type'(cur_ff);
            mem_wr_data = mem_rd_data;
            state_in    = SWAP_WR2;
         end
         SWAP_WR2: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_type'(step_idx);
            mem_wr_data = hold_ff;
            state_in    = DONE;
         end
         REM_HEAD: begin
            hout_in = mem_rd_data;
            wa_in   = cur_ff;
            if (step_ok) begin
               mem_rd_addr = addr_type'(step_idx);
               cur_in      = step_idx;
               state_in    = REM_SHIFT;
            end else begin
               count_in = cnt_type'(count_ff - 1'b1);
               state_in = DONE;
            end
         end
         REM_SHIFT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_type'(wa_ff);
            mem_wr_data = mem_rd_data;
            wa_in       = cur_ff;
            if (step_ok) begin
               mem_rd_addr = addr_type'(step_idx);
               cur_in      = step_idx;
            end else begin
               count_in = cnt_type'(count_ff - 1'b1);
               state_in = DONE;
            end
         end
         REP_WR: begin
            hout_in     = mem_rd_data;
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_type'(cur_ff);
            mem_wr_data = hreq_ff;
            state_in    = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_handle_in = HANDLE_PORT_W'(hout_ff);
               rsp_count_in  = ENTRY_COUNT_W'(count_ff);
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      wa_ff         <= wa_in;
      hold_ff       <= hold_in;
      hreq_ff       <= hreq_in;
      status_ff     <= status_in;
      hout_ff       <= hout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_handle_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire

[src/bounded_ordered_list_engine.sv]
// Append, clear, unused opcodes, refusals and swaps at an end go straight to the response
// state; get and replace first wait for the store read; a swap that moves entries reads
// both and writes both; remove shifts every later entry down, one entry a cycle through the
// single store port. One request at a time; the next is taken once the response register is
// loaded. Reset clears the count, sequencer and response valid; slots at or past the count
// are never returned.
`default_nettype none

module bounded_ordered_list_engine #(
   parameter int LIST_DEPTH   = bole_pkg::LIST_DEPTH_DEF,
   parameter int HANDLE_WIDTH = bole_pkg::HANDLE_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic [bole_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire logic [bole_pkg::POSITION_W-1:0]       req_position,
   input  wire logic [bole_pkg::HANDLE_PORT_W-1:0]    req_handle_in,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic [bole_pkg::STATUS_W-1:0]         rsp_status,
   output      logic [bole_pkg::HANDLE_PORT_W-1:0]    rsp_handle_out,
   output      logic [bole_pkg::ENTRY_COUNT_W-1:0]    rsp_entry_count
);

   import bole_pkg::*;

   localparam int ADDR_W = $clog2(LIST_DEPTH);

   logic                    mem_wr_en;
   logic [ADDR_W-1:0]       mem_wr_addr;
   logic [HANDLE_WIDTH-1:0] mem_wr_data;
   logic [ADDR_W-1:0]       mem_rd_addr;
   logic [HANDLE_WIDTH-1:0] mem_rd_data;

   bole_ctrl #(
      .LIST_DEPTH   (LIST_DEPTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_handle_in   (req_handle_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_entry_count (rsp_entry_count),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   bole_store #(
      .LIST_DEPTH   (LIST_DEPTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but engine not busy afterwards");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         rsp_entry_count == ENTRY_COUNT_W'(LIST_DEPTH))
      else $error("full status with list not at capacity");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_handle_out == '0)
      else $error("refused request returned a handle");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_CLEAR) |=>
         (!req_stall) [->1] ##0 (rsp_valid && rsp_entry_count == '0))
      else $error("clear did not empty the list");

endmodule

`default_nettype wire
